// ----- hw/rtl/assert_macros.svh -----
// Assertion macros, included by matrix_inverse_3x3.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/mi3_pkg.sv -----
// Types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

  localparam int ELEM_W     = 32;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int COF_W      = 64;
  localparam int PART_W     = 96;
  localparam int DET_W      = 98;
  localparam int THR_W      = 31;
  localparam int QUO_W      = 32;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [8:0] mat_t;

endpackage

// ----- hw/rtl/matrix_inverse_3x3.sv -----
// Top level of the pipelined 3x3 matrix inverse by adjugate.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid_i/in_stall_o   | col0_row0_i .. col2_row2_i
//   out     | output    | out_valid_o/out_stall_i | inv_*_o, singular_o
//   cfg     | input     | cfg_we_i             | cfg_wdata_i (threshold)
//
// One matrix per cycle while the output is not stalled, through 24 register
// stages: 6 product and determinant stages, a numerator load stage, 16
// two-bit-per-stage quotient stages and the output register.
// Reset clears all stage valid bits and the threshold register.
// A stall drains bubbles first: a stage loads whenever it is empty or the
// stage after it moves, so input is taken while any stage is free.
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [THR_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [ELEM_W-1:0] col0_row0_i,
  input  logic signed [ELEM_W-1:0] col0_row1_i,
  input  logic signed [ELEM_W-1:0] col0_row2_i,
  input  logic signed [ELEM_W-1:0] col1_row0_i,
  input  logic signed [ELEM_W-1:0] col1_row1_i,
  input  logic signed [ELEM_W-1:0] col1_row2_i,
  input  logic signed [ELEM_W-1:0] col2_row0_i,
  input  logic signed [ELEM_W-1:0] col2_row1_i,
  input  logic signed [ELEM_W-1:0] col2_row2_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [ELEM_W-1:0] inv_col0_row0_o,
  output logic signed [ELEM_W-1:0] inv_col0_row1_o,
  output logic signed [ELEM_W-1:0] inv_col0_row2_o,
  output logic signed [ELEM_W-1:0] inv_col1_row0_o,
  output logic signed [ELEM_W-1:0] inv_col1_row1_o,
  output logic signed [ELEM_W-1:0] inv_col1_row2_o,
  output logic signed [ELEM_W-1:0] inv_col2_row0_o,
  output logic signed [ELEM_W-1:0] inv_col2_row1_o,
  output logic signed [ELEM_W-1:0] inv_col2_row2_o,
  output logic              singular_o
);

  `include "assert_macros.svh"

  localparam int DET_ST    = 5;
  localparam int DIV_FIRST = DET_ST + 1;
  localparam int DIV_LAST  = DIV_FIRST + DIV_STAGES;
  localparam int OUT_ST    = DIV_LAST + 1;
  localparam int NST       = OUT_ST + 1;

  logic [THR_W-1:0] thr_q;
  logic [NST-1:0]   v_q;
  logic [NST-1:0]   en;
  mat_t             in_mat;
  mat_t             mat_q [0:DIV_LAST];
  mat_t             res_q;
  mat_t             res_d;
  logic             sing_q [DET_ST:OUT_ST];

  logic signed [PROD_W-1:0] pa_q [0:2][0:2];
  logic signed [PROD_W-1:0] pb_q [0:2][0:2];
  logic signed [COF_W-1:0]  cof_q [1:4][0:2][0:2];
  logic signed [COF_W:0]    plo_q [0:2];
  logic signed [PROD_W-1:0] phi_q [0:2];
  logic signed [PART_W-1:0] prod_q [0:2];
  logic signed [DET_W-1:0]  det_q;
  logic [DET_W-1:0]         dmag_q;
  logic [DET_W-1:0]         dmag_d;
  logic [DET_W-1:0]         lim;
  logic [COF_W-1:0]         cmag_q [0:8];
  logic                     cneg_q [0:8];
  logic [ELEM_W-1:0]        div_res [0:8];

  assign in_mat = {col2_row2_i, col2_row1_i, col2_row0_i,
                   col1_row2_i, col1_row1_i, col1_row0_i,
                   col0_row2_i, col0_row1_i, col0_row0_i};

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Stage enables: load when empty or when the next stage moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[OUT_ST];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Carry the input matrix along for the singular case
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mat_q[0] <= in_mat;
    end
    for (int k = 1; k <= DIV_LAST; k++) begin
      if (en[k]) begin
        mat_q[k] <= mat_q[k-1];
      end
    end
  end

  // Stage 0: cross product terms, X_i = col(i+1) x col(i+2)
  for (genvar i = 0; i < 3; i++) begin : g_cross
    for (genvar c = 0; c < 3; c++) begin : g_comp
      always_ff @(posedge clk_i) begin
        if (en[0]) begin
          pa_q[i][c] <= in_mat[((i+1)%3)*3 + (c+1)%3] * in_mat[((i+2)%3)*3 + (c+2)%3];
          pb_q[i][c] <= in_mat[((i+1)%3)*3 + (c+2)%3] * in_mat[((i+2)%3)*3 + (c+1)%3];
        end
      end
    end
  end

  // Stage 1: cofactors; stages 2 to 4 hold them
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          cof_q[1][i][c] <= pa_q[i][c] - pb_q[i][c];
        end
      end
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        cof_q[k] <= cof_q[k-1];
      end
    end
  end

  // Stage 2: split column 0 dot X0 into 32 by 32 partial products
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        plo_q[c] <= mat_q[1][c] * $signed({1'b0, cof_q[1][0][c][ELEM_W-1:0]});
        phi_q[c] <= mat_q[1][c] * $signed(cof_q[1][0][c][COF_W-1:ELEM_W]);
      end
    end
  end

  // Stage 3: recombine partial products
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= (PART_W'(phi_q[c]) <<< ELEM_W) + PART_W'(plo_q[c]);
      end
    end
  end

  // Stage 4: determinant
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      det_q <= DET_W'(prod_q[0]) + DET_W'(prod_q[1]) + DET_W'(prod_q[2]);
    end
  end

  // Stage 5: magnitudes, signs and the near-zero test
  assign dmag_d = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
  assign lim    = DET_W'(thr_q) << (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en[DET_ST]) begin
      dmag_q         <= dmag_d;
      sing_q[DET_ST] <= dmag_d <= lim;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          cmag_q[c*3 + r] <= cof_q[4][r][c][COF_W-1] ? COF_W'(-cof_q[4][r][c])
                                                     : COF_W'(cof_q[4][r][c]);
          cneg_q[c*3 + r] <= cof_q[4][r][c][COF_W-1] ^ det_q[DET_W-1];
        end
      end
    end
    // Hold the singular flag alongside the quotient pipelines
    for (int k = DET_ST + 1; k <= OUT_ST; k++) begin
      if (en[k]) begin
        sing_q[k] <= sing_q[k-1];
      end
    end
  end

  // One quotient pipeline per element
  for (genvar e = 0; e < 9; e++) begin : g_div
    mi3_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en[DIV_LAST:DIV_FIRST]),
      .mag_i  (cmag_q[e]),
      .neg_i  (cneg_q[e]),
      .dmag_i (dmag_q),
      .res_o  (div_res[e])
    );
  end

  // Output stage: pick the inverse or the unchanged input
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      res_d[e] = sing_q[DIV_LAST] ? mat_q[DIV_LAST][e] : $signed(div_res[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_ST]) begin
      res_q <= res_d;
    end
  end

  assign inv_col0_row0_o = res_q[0];
  assign inv_col0_row1_o = res_q[1];
  assign inv_col0_row2_o = res_q[2];
  assign inv_col1_row0_o = res_q[3];
  assign inv_col1_row1_o = res_q[4];
  assign inv_col1_row2_o = res_q[5];
  assign inv_col2_row0_o = res_q[6];
  assign inv_col2_row1_o = res_q[7];
  assign inv_col2_row2_o = res_q[8];
  assign singular_o      = sing_q[OUT_ST];

  `ASSERT_NEVER(a_stall_with_bubble, clk_i, rst_ni, !(&v_q) && in_stall_o, "input stalled with a free stage")
  `ASSERT_CLK(a_accept_enters, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> v_q[0], "accepted beat lost at entry")
  `ASSERT_CLK(a_zero_det_singular, clk_i, rst_ni, (v_q[DET_ST] && dmag_q == '0) |-> sing_q[DET_ST], "zero determinant not flagged singular")

endmodule

// ----- hw/rtl/mi3_div.sv -----
// Pipelined restoring divider with saturation for one inverse element.
module mi3_div
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [DIV_STAGES:0]   en_i,
  input  logic [COF_W-1:0]      mag_i,
  input  logic                  neg_i,
  input  logic [DET_W-1:0]      dmag_i,
  output logic [ELEM_W-1:0]     res_o
);

  localparam int NW = COF_W + 2 * FRAC_BITS;
  localparam int CW = DET_W + QUO_W;

  logic [NW-1:0]    rem_q  [0:DIV_STAGES];
  logic [QUO_W-1:0] quo_q  [0:DIV_STAGES];
  logic [DET_W-1:0] dmag_q [0:DIV_STAGES];
  logic             neg_q  [0:DIV_STAGES];
  logic             ovf_q  [0:DIV_STAGES];

  logic [NW-1:0] num;
  logic          ovf_d;

  // Scale the numerator and flag quotients that do not fit in the word
  assign num   = NW'(mag_i) << (2 * FRAC_BITS);
  assign ovf_d = CW'(num) >= (CW'(dmag_i) << QUO_W);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= num;
      quo_q[0]  <= '0;
      dmag_q[0] <= dmag_i;
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= ovf_d;
    end
  end

  // Resolve DIV_BITS quotient bits per stage, most significant first
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [NW-1:0]    rem_c;
    logic [QUO_W-1:0] quo_c;

    always_comb begin
      logic [CW-1:0] sh;
      rem_c = rem_q[k-1];
      quo_c = quo_q[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        sh = CW'(dmag_q[k-1]) << (QUO_W - 1 - (k - 1) * DIV_BITS - j);
        if (CW'(rem_c) >= sh) begin
          rem_c = NW'(CW'(rem_c) - sh);
          quo_c[QUO_W - 1 - (k - 1) * DIV_BITS - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= rem_c;
        quo_q[k]  <= quo_c;
        dmag_q[k] <= dmag_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  // Apply sign and saturate to the signed element range
  always_comb begin
    if (ovf_q[DIV_STAGES] || quo_q[DIV_STAGES][QUO_W-1]) begin
      res_o = neg_q[DIV_STAGES] ? SAT_NEG : SAT_POS;
    end else if (neg_q[DIV_STAGES]) begin
      res_o = ELEM_W'(-quo_q[DIV_STAGES]);
    end else begin
      res_o = ELEM_W'(quo_q[DIV_STAGES]);
    end
  end

endmodule
